// ===== rtl/core/rcrt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rcrt_pkg - shared types and constants of the call/return tracker
// Item layouts of both ports, the decoded operation that travels from the
// front to the back, opcodes and link-register numbers.
// ----------------------------------------------------------------------------
package rcrt_pkg;

  localparam int STACK_DEPTH_DEF = 128;
  localparam int OPQ_DEPTH       = 4;
  localparam int OUTQ_DEPTH      = 4;

  localparam logic [6:0] OPC_JAL  = 7'b1101111;
  localparam logic [6:0] OPC_JALR = 7'b1100111;

  localparam logic [4:0] REG_RA = 5'd1;
  localparam logic [4:0] REG_T0 = 5'd5;

  localparam logic KIND_CALL = 1'b0;
  localparam logic KIND_RET  = 1'b1;

  typedef struct packed {
    logic [31:0] instr_pc;
    logic [31:0] instr_word;
    logic [31:0] rs1_value;
  } in_item_t;

  typedef struct packed {
    logic        event_kind;
    logic [31:0] event_pc;
    logic [31:0] callee_addr;
    logic [7:0]  nest_depth;
    logic        last_of_run;
  } out_item_t;

  // Stack operation produced by the front: a return, a call, or both
  // (return first).
  typedef struct packed {
    logic [31:0] pc;
    logic [31:0] target;
    logic        do_ret;
    logic        do_call;
  } op_t;

endpackage : rcrt_pkg
`default_nettype wire

// ===== rtl/core/riscv_call_return_tracker_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// riscv_call_return_tracker_core - RV32 call/return tracker
// Follows JAL/JALR of retired instructions, keeps a bounded callee-address
// stack; reports calls, and returns on a non-empty stack, with their depth.
// ----------------------------------------------------------------------------
//
//  channel   ports                              beat
//  --------  ---------------------------------  -------------------------------
//  input     in_push / in_full / in_data        push & !full: one instruction
//  result    out_pop / out_empty / out_data     pop & !empty: one call/return
//  config    cfg_valid / cfg_ready /            valid & ready: trace enable
//            cfg_trace_enable
//
//  One instruction is taken per cycle while in_full is low; a call or return
//  result goes from decode through the operation queue, the stack step and the
//  result queue. A JALR that returns and then calls takes a return step, then
//  a call step, in the single-port stack unit; in all other cases it takes one
//  item per cycle unless the result side stalls. Such stalls fill the result
//  queue, then the operation queue, and only then raise in_full. Reset clears
//  the stack, the queues and the trace enable; stack entries need no clearing.
//
module riscv_call_return_tracker_core
  import rcrt_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     cfg_valid,
  output logic          cfg_ready,
  input  wire logic     cfg_trace_enable,
  input  wire logic     in_push,
  output logic          in_full,
  input  wire in_item_t in_data,
  output logic          out_empty,
  input  wire logic     out_pop,
  output out_item_t     out_data
);

  op_t       fr_op, q_op;
  logic      fr_wr, opq_full, opq_empty, op_pop;
  logic      res_valid, outq_full;
  out_item_t res;

  // hold input while the operation queue is full
  assign in_full = opq_full;

  rcrt_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_trace_enable (cfg_trace_enable),
    .in_push          (in_push),
    .in_data          (in_data),
    .op_full          (opq_full),
    .op_wr            (fr_wr),
    .op               (fr_op)
  );

  // decouple decode from the stack step
  rcrt_fifo #(
    .WIDTH ($bits(op_t)),
    .DEPTH (OPQ_DEPTH)
  ) u_opq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fr_wr),
    .wr_data (fr_op),
    .full    (opq_full),
    .rd_en   (op_pop),
    .rd_data (q_op),
    .empty   (opq_empty)
  );

  rcrt_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (!opq_empty),
    .op        (q_op),
    .op_pop    (op_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_full  (outq_full)
  );

  // result queue: advance results while the consumer stalls
  rcrt_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_valid),
    .wr_data (res),
    .full    (outq_full),
    .rd_en   (out_pop),
    .rd_data (out_data),
    .empty   (out_empty)
  );

endmodule : riscv_call_return_tracker_core
`default_nettype wire

// ===== rtl/core/rcrt_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rcrt_fifo - small register queue
// Fixed-depth first-in first-out buffer; the head entry is shown while
// empty is low.
// ----------------------------------------------------------------------------
module rcrt_fifo
  import rcrt_pkg::*;
#(
  parameter int WIDTH = 32,
  parameter int DEPTH = OPQ_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule : rcrt_fifo
`default_nettype wire

// ===== rtl/core/rcrt_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rcrt_front - decode and classify
// Holds the trace enable, decodes JAL/JALR, forms the jump target and
// applies the link-register hints; only stack operations move on.
// ----------------------------------------------------------------------------
module rcrt_front
  import rcrt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     cfg_valid,
  output logic          cfg_ready,
  input  wire logic     cfg_trace_enable,
  input  wire logic     in_push,
  input  wire in_item_t in_data,
  input  wire logic     op_full,
  output logic          op_wr,
  output op_t           op
);

  logic        trace_enable_r, trace_enable_nxt;
  logic [6:0]  opcode;
  logic [4:0]  rd, rs1;
  logic        rd_link, rs1_link;
  logic [31:0] jal_imm, jalr_imm, jalr_sum;
  logic        is_jal, is_jalr;

  assign cfg_ready = 1'b1;

  always_comb begin
    trace_enable_nxt = trace_enable_r;
    if (cfg_valid) begin
      trace_enable_nxt = cfg_trace_enable;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trace_enable_r <= 1'b0;
    end else begin
      trace_enable_r <= trace_enable_nxt;
    end
  end

  assign opcode   = in_data.instr_word[6:0];
  assign rd       = in_data.instr_word[11:7];
  assign rs1      = in_data.instr_word[19:15];
  assign rd_link  = (rd == REG_RA) || (rd == REG_T0);
  assign rs1_link = (rs1 == REG_RA) || (rs1 == REG_T0);
  assign is_jal   = (opcode == OPC_JAL);
  assign is_jalr  = (opcode == OPC_JALR);

  assign jal_imm  = {{11{in_data.instr_word[31]}}, in_data.instr_word[31],
                     in_data.instr_word[19:12], in_data.instr_word[20],
                     in_data.instr_word[30:21], 1'b0};
  assign jalr_imm = {{20{in_data.instr_word[31]}}, in_data.instr_word[31:20]};
  assign jalr_sum = in_data.rs1_value + jalr_imm;

  always_comb begin
    op.pc      = in_data.instr_pc;
    op.target  = in_data.instr_pc + jal_imm;
    op.do_ret  = 1'b0;
    op.do_call = 1'b0;
    if (is_jal) begin
      op.do_call = rd_link;
    end else if (is_jalr) begin
      // clear bit 0 of the register-relative target
      op.target  = {jalr_sum[31:1], 1'b0};
      op.do_call = rd_link;
      op.do_ret  = rs1_link && (!rd_link || (rd != rs1));
    end
  end

  // drop items while tracing is off and items that touch no stack
  assign op_wr = in_push && !op_full && trace_enable_r && (op.do_ret || op.do_call);

endmodule : rcrt_front
`default_nettype wire

// ===== rtl/core/rcrt_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rcrt_back - stack execution
// Runs queued stack operations against the callee stack memory and builds
// the result items; a return-then-call operation takes two steps.
// ----------------------------------------------------------------------------
module rcrt_back
  import rcrt_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic op_valid,
  input  wire op_t  op,
  output logic      op_pop,
  output logic      res_valid,
  output out_item_t res,
  input  wire logic res_full
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);

  logic [31:0]   stack_mem_r [STACK_DEPTH];
  logic [31:0]   rd_data_r;

  logic [CW-1:0] count_r, count_nxt;
  logic          ph_r, ph_nxt;
  logic [CW-1:0] cnt_m1;
  logic [CW+7:0] depth_ret_w, depth_call_w;

  logic          s2_valid_r, s2_valid_nxt;
  logic          s2_kind_r;
  logic [31:0]   s2_pc_r;
  logic [31:0]   s2_addr_r;
  logic [7:0]    s2_depth_r;
  logic          s2_last_r;

  logic          ret_part, ret_hit, emit, s1_fire, push_ok, rd_en, wr_en;

  assign cnt_m1       = count_r - CW'(1);
  assign depth_ret_w  = {8'b0, cnt_m1};
  assign depth_call_w = {8'b0, count_r};

  assign ret_part = op.do_ret && !ph_r;
  assign ret_hit  = ret_part && (count_r != '0);
  assign emit     = ret_part ? ret_hit : 1'b1;
  assign push_ok  = (count_r < FULL_CNT);
  assign s1_fire  = op_valid && (!s2_valid_r || !res_full);
  assign op_pop   = s1_fire && !(ret_part && op.do_call);
  assign rd_en    = s1_fire && ret_hit;
  assign wr_en    = s1_fire && !ret_part && push_ok;

  always_comb begin
    count_nxt    = count_r;
    ph_nxt       = ph_r;
    s2_valid_nxt = s2_valid_r;
    if (s2_valid_r && !res_full) begin
      s2_valid_nxt = 1'b0;
    end
    if (s1_fire) begin
      ph_nxt = ret_part && op.do_call;
      if (ret_hit) begin
        count_nxt = cnt_m1;
      end else if (wr_en) begin
        count_nxt = count_r + CW'(1);
      end
      if (emit) begin
        s2_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      ph_r       <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      ph_r       <= ph_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  // result payload, loaded with each emitted step
  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      s2_kind_r  <= ret_part ? KIND_RET : KIND_CALL;
      s2_pc_r    <= op.pc;
      s2_addr_r  <= op.target;
      s2_depth_r <= ret_part ? depth_ret_w[7:0] : depth_call_w[7:0];
      s2_last_r  <= ret_part ? !op.do_call : 1'b1;
    end
  end

  // callee stack: a read (pop) and a write (push) never happen in the same step
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= stack_mem_r[cnt_m1[AW-1:0]];
    end
    if (wr_en) begin
      stack_mem_r[count_r[AW-1:0]] <= op.target;
    end
  end

  assign res_valid       = s2_valid_r;
  assign res.event_kind  = s2_kind_r;
  assign res.event_pc    = s2_pc_r;
  assign res.callee_addr = (s2_kind_r == KIND_RET) ? rd_data_r : s2_addr_r;
  assign res.nest_depth  = s2_depth_r;
  assign res.last_of_run = s2_last_r;

endmodule : rcrt_back
`default_nettype wire
